[rtl/rds_pkg.sv]
`default_nettype none
package rds_pkg;

  localparam int unsigned AngW   = 15;
  localparam int unsigned TrigW  = 16;
  localparam int unsigned StepW  = 32;
  localparam int unsigned MapW   = 16;
  localparam int unsigned Q30W   = 31;

  localparam logic [AngW-1:0] TwoPiQ12     = 15'd25736;
  localparam logic [Q30W-1:0] HalfPiQ30    = 31'd1686629713;
  localparam logic [Q30W-1:0] QuarterPiQ30 = 31'd843314856;
  localparam logic [Q30W-1:0] OneQ30       = 31'd1073741824;

  // reciprocal divider: 32 quotient bits cover (2^31 + m) / 2m for m >= 1
  localparam int unsigned RecipBits = 32;

  typedef enum logic [0:0] {
    CfgMapWidth  = 1'b0,
    CfgMapHeight = 1'b1
  } cfg_idx_e;

  // payload carried along the cell chain
  typedef struct packed {
    logic [AngW-1:0]  angle;
    logic [1:0]       quad;
    logic             mirror;
    logic [Q30W-1:0]  x;
    logic [Q30W-1:0]  x2;
    logic [Q30W-1:0]  ts;
    logic [Q30W-1:0]  tc;
    logic [Q30W-1:0]  sr;
    logic [Q30W-1:0]  cr;
    logic signed [TrigW-1:0] s;
    logic signed [TrigW-1:0] c;
    logic [RecipBits:0] remx;
    logic [RecipBits:0] remy;
    logic [RecipBits-1:0] qx;
    logic [RecipBits-1:0] qy;
  } cell_data_t;

  // truncated Q30 product
  function automatic logic [Q30W-1:0] mul30(input logic [Q30W-1:0] a,
                                            input logic [Q30W-1:0] b);
    logic [2*Q30W-1:0] p;
    p = {{Q30W{1'b0}}, a} * {{Q30W{1'b0}}, b};
    return p[Q30W+29:30];
  endfunction

  function automatic logic [TrigW-1:0] to_q14(input logic [Q30W-1:0] v);
    logic [Q30W:0] t;
    t = {1'b0, v} + (Q30W+1)'(32768);
    return TrigW'(t[Q30W:16]);
  endfunction

endpackage
`default_nettype wire

[rtl/rds_stream_if.sv]
`default_nettype none
interface rds_stream_if #(parameter int unsigned Width = 8);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/rds_poly_cell.sv]
`default_nettype none
// one step of both polynomials; Stage picks squaring, product, constant division or the final products
module rds_poly_cell #(
  parameter int unsigned Stage = 0
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire rds_pkg::cell_data_t d_i,
  output      rds_pkg::cell_data_t d_o
);
  // divisors of this stage, done as exact reciprocal multiplication
  localparam int unsigned DivS = (Stage <= 1) ? 42 : ((Stage <= 3) ? 20 : 6);
  localparam int unsigned DivC = (Stage <= 1) ? 56 : ((Stage <= 3) ? 30 : 12);
  localparam int unsigned ShS  = rds_pkg::Q30W + $clog2(DivS);
  localparam int unsigned ShC  = rds_pkg::Q30W + $clog2(DivC);
  localparam logic [31:0] MagS = 32'(((64'd1 << ShS) + 64'(DivS) - 64'd1) / 64'(DivS));
  localparam logic [31:0] MagC = 32'(((64'd1 << ShC) + 64'(DivC) - 64'd1) / 64'(DivC));

  rds_pkg::cell_data_t d_d, d_q;
  logic [rds_pkg::Q30W-1:0] ps, pc, ns, nc, qs, qc;
  logic [63:0] ms, mc;

  always_comb begin
    d_d = d_i;
    ps  = rds_pkg::mul30(d_i.x2, d_i.ts);
    pc  = rds_pkg::mul30(d_i.x2, d_i.tc);
    ns  = (Stage == 1) ? d_i.x2 : d_i.ts;
    nc  = (Stage == 1) ? d_i.x2 : d_i.tc;
    ms  = {33'd0, ns} * {32'd0, MagS};
    mc  = {33'd0, nc} * {32'd0, MagC};
    qs  = rds_pkg::Q30W'(ms >> ShS);
    qc  = rds_pkg::Q30W'(mc >> ShC);
    unique case (Stage)
      0: begin
        d_d.x2 = rds_pkg::mul30(d_i.x, d_i.x);
      end
      1, 3, 5: begin
        d_d.ts = rds_pkg::OneQ30 - qs;
        d_d.tc = rds_pkg::OneQ30 - qc;
      end
      2, 4: begin
        d_d.ts = ps;
        d_d.tc = pc;
      end
      default: begin
        d_d.sr = rds_pkg::mul30(d_i.x, d_i.ts);
        d_d.cr = rds_pkg::OneQ30 - (pc >> 1);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end
  assign d_o = d_q;
endmodule
`default_nettype wire

[rtl/rds_div_cell.sv]
`default_nettype none
// one restoring division bit for both reciprocals
module rds_div_cell (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire rds_pkg::cell_data_t d_i,
  output      rds_pkg::cell_data_t d_o
);
  localparam int unsigned B = rds_pkg::RecipBits;
  rds_pkg::cell_data_t d_d, d_q;
  logic [B:0] dx, dy, rx, ry;

  always_comb begin
    d_d = d_i;
    dx  = (B+1)'({d_i.c[rds_pkg::TrigW-1] ? -d_i.c : d_i.c, 1'b0});
    dy  = (B+1)'({d_i.s[rds_pkg::TrigW-1] ? -d_i.s : d_i.s, 1'b0});
    rx  = {d_i.remx[B-1:0], d_i.qx[B-1]};
    ry  = {d_i.remy[B-1:0], d_i.qy[B-1]};
    d_d.qx = {d_i.qx[B-2:0], rx >= dx};
    d_d.qy = {d_i.qy[B-2:0], ry >= dy};
    d_d.remx = (rx >= dx) ? rx - dx : rx;
    d_d.remy = (ry >= dy) ? ry - dy : ry;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end
  assign d_o = d_q;
endmodule
`default_nettype wire

[rtl/ray_direction_setup.sv]
`default_nettype none
// Ray direction setup: each request (view direction, ray offset) yields the wrapped
// ray angle, Q1.14 cosine and sine, and Q15.16 reciprocals (map size when zero).
// A chain of cells: wrap/reduce, seven polynomial cells (products and constant
// divisions on alternate cells), quadrant rounding, then 32 divider cells, one
// quotient bit each, and a result register. One request is taken every cycle while
// the output is not stalled, and a stall freezes the chain.
module ray_direction_setup (
  input wire logic clk_i,
  input wire logic rst_ni,
  rds_stream_if.sink   in_ch,
  rds_stream_if.sink   cfg_ch,
  rds_stream_if.source out_ch
);
  localparam int unsigned NP = 7;
  localparam int unsigned ND = rds_pkg::RecipBits;
  localparam int unsigned NS = NP + ND + 3;
  localparam int unsigned W  = rds_pkg::AngW;
  localparam int unsigned AW = rds_pkg::Q30W + 2;
  localparam logic [AW-1:0] HalfPi1 = AW'(rds_pkg::HalfPiQ30);
  localparam logic [AW-1:0] HalfPi2 = HalfPi1 + HalfPi1;
  localparam logic [AW-1:0] HalfPi3 = HalfPi2 + HalfPi1;

  logic [rds_pkg::MapW-1:0] map_width_q, map_height_q;
  logic [NS-1:0] vld_q;
  logic en;
  rds_pkg::cell_data_t c0_d, c0_q, r_d, r_q;
  rds_pkg::cell_data_t pc [NP+1];
  rds_pkg::cell_data_t dc [ND+1];
  logic signed [W+1:0] ang_s;
  logic [W-1:0] ang;
  logic [AW-1:0] a30;
  logic [rds_pkg::Q30W-1:0] rem;
  logic [1:0] quad;
  logic [rds_pkg::TrigW-1:0] s14, c14;
  logic [rds_pkg::StepW-1:0] sx, sy, rx, ry;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = vld_q[NS-1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= '0;
      map_height_q <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data[47:32] == 16'(rds_pkg::CfgMapWidth))  map_width_q  <= cfg_ch.data[15:0];
      if (cfg_ch.data[47:32] == 16'(rds_pkg::CfgMapHeight)) map_height_q <= cfg_ch.data[15:0];
    end
  end

  // angle wrap and quadrant split
  always_comb begin
    ang_s = $signed({2'b00, in_ch.data[2*W-1:W]}) -
            $signed({{2{in_ch.data[W-1]}}, in_ch.data[W-1:0]});
    if (ang_s < 0) ang = W'(ang_s + $signed({1'b0, rds_pkg::TwoPiQ12}));
    else if (ang_s >= $signed({1'b0, rds_pkg::TwoPiQ12}))
      ang = W'(ang_s - $signed({1'b0, rds_pkg::TwoPiQ12}));
    else ang = W'(ang_s);
    a30 = {ang, 18'd0};
    quad = 2'd0; rem = rds_pkg::Q30W'(a30);
    if (a30 >= HalfPi1) begin quad = 2'd1; rem = rds_pkg::Q30W'(a30 - HalfPi1); end
    if (a30 >= HalfPi2) begin quad = 2'd2; rem = rds_pkg::Q30W'(a30 - HalfPi2); end
    if (a30 >= HalfPi3) begin quad = 2'd3; rem = rds_pkg::Q30W'(a30 - HalfPi3); end
    c0_d = '0;
    c0_d.angle = ang;
    c0_d.quad = quad;
    c0_d.mirror = rem > rds_pkg::QuarterPiQ30;
    c0_d.x = c0_d.mirror ? rds_pkg::HalfPiQ30 - rem : rem;
  end

  always_ff @(posedge clk_i) begin
    if (en) c0_q <= c0_d;
  end

  // polynomial cells
  assign pc[0] = c0_q;
  for (genvar g = 0; g < NP; g++) begin : g_poly
    rds_poly_cell #(.Stage(g)) u_cell (.clk_i, .en_i(en), .d_i(pc[g]), .d_o(pc[g+1]));
  end

  // quadrant signs and dividend seed
  always_comb begin
    r_d = pc[NP];
    s14 = rds_pkg::to_q14(pc[NP].mirror ? pc[NP].cr : pc[NP].sr);
    c14 = rds_pkg::to_q14(pc[NP].mirror ? pc[NP].sr : pc[NP].cr);
    unique case (pc[NP].quad)
      2'd0: begin r_d.s = s14;  r_d.c = c14;  end
      2'd1: begin r_d.s = c14;  r_d.c = -s14; end
      2'd2: begin r_d.s = -s14; r_d.c = -c14; end
      default: begin r_d.s = -c14; r_d.c = s14; end
    endcase
    r_d.remx = '0; r_d.remy = '0;
    r_d.qx = 32'h8000_0000 + 32'(r_d.c[15] ? -r_d.c : r_d.c);
    r_d.qy = 32'h8000_0000 + 32'(r_d.s[15] ? -r_d.s : r_d.s);
  end

  always_ff @(posedge clk_i) begin
    if (en) r_q <= r_d;
  end

  // divider cells
  assign dc[0] = r_q;
  for (genvar g = 0; g < ND; g++) begin : g_div
    rds_div_cell u_cell (.clk_i, .en_i(en), .d_i(dc[g]), .d_o(dc[g+1]));
  end

  // result formatting
  always_comb begin
    rx = dc[ND].c[15] ? -dc[ND].qx : dc[ND].qx;
    ry = dc[ND].s[15] ? -dc[ND].qy : dc[ND].qy;
    sx = (dc[ND].c != 0) ? rx :
         (map_width_q[15] ? 32'h7FFF_FFFF : {map_width_q, 16'd0});
    sy = (dc[ND].s != 0) ? ry :
         (map_height_q[15] ? 32'h7FFF_FFFF : {map_height_q, 16'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en) out_ch.data <= {sy, sx, dc[ND].s, dc[ND].c, dc[ND].angle};
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NS-2:0], in_ch.valid};
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_ang: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.data[W-1:0] < rds_pkg::TwoPiQ12)
    else $error("angle out of range");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
endmodule
`default_nettype wire

[sim/ray_direction_setup_tb.sv]
module ray_direction_setup_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned HalfPi   = 64'd1686629713;
  localparam longint unsigned QuartPi  = 64'd843314856;
  localparam longint unsigned OneQ     = 64'd1073741824;
  localparam longint          StepMax  = 64'sd2147483647;
  localparam int              DrainWait = 45;
  localparam int              StallLimit = 5000;

  typedef struct packed {
    logic [31:0] sy;
    logic [31:0] sx;
    logic [15:0] sinv;
    logic [15:0] cosv;
    logic [14:0] angle;
  } ray_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rds_stream_if #(.Width(30))  in_ch  ();
  rds_stream_if #(.Width(48))  cfg_ch ();
  rds_stream_if #(.Width(111)) out_ch ();

  ray_direction_setup u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .cfg_ch (cfg_ch.sink),
    .out_ch (out_ch.source)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] map_w_q = '0;
  logic [15:0] map_h_q = '0;
  ray_res_t    pending_rays[$];
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  bit          stall_on = 1'b1;

  // trig and reciprocal prediction
  function automatic longint unsigned m30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned sin_poly(longint unsigned x);
    longint unsigned x2, t;
    x2 = m30(x, x);
    t = OneQ - x2 / 42;
    t = OneQ - m30(x2, t) / 20;
    t = OneQ - m30(x2, t) / 6;
    return m30(x, t);
  endfunction

  function automatic longint unsigned cos_poly(longint unsigned x);
    longint unsigned x2, t;
    x2 = m30(x, x);
    t = OneQ - x2 / 56;
    t = OneQ - m30(x2, t) / 30;
    t = OneQ - m30(x2, t) / 12;
    return OneQ - m30(x2, t) / 2;
  endfunction

  function automatic longint round_q14(longint unsigned v);
    return longint'((v + 64'd32768) >> 16);
  endfunction

  function automatic longint step_of(longint c, logic [15:0] fallback);
    longint m, r;
    if (c == 0) begin
      r = longint'({fallback, 16'h0});
      return (r > StepMax) ? StepMax : r;
    end
    m = (c < 0) ? -c : c;
    r = (64'sd2147483648 + m) / (2 * m);
    if (r > StepMax) r = StepMax;
    return (c < 0) ? -r : r;
  endfunction

  function automatic ray_res_t predict_ray(logic [14:0] dir, logic [14:0] off);
    ray_res_t res;
    longint ang, s, c;
    longint unsigned a30, q, r, sr, cr;
    ang = longint'(dir) - longint'($signed(off));
    if (ang < 0) ang += 25736;
    else if (ang >= 25736) ang -= 25736;
    a30 = longint'(ang) << 18;
    q = a30 / HalfPi;
    r = a30 - q * HalfPi;
    if (r <= QuartPi) begin
      sr = sin_poly(r);
      cr = cos_poly(r);
    end else begin
      sr = cos_poly(HalfPi - r);
      cr = sin_poly(HalfPi - r);
    end
    case (q & 3)
      0: begin s = round_q14(sr); c = round_q14(cr); end
      1: begin s = round_q14(cr); c = -round_q14(sr); end
      2: begin s = -round_q14(sr); c = -round_q14(cr); end
      default: begin s = -round_q14(cr); c = round_q14(sr); end
    endcase
    res.angle = ang[14:0];
    res.cosv  = c[15:0];
    res.sinv  = s[15:0];
    res.sx    = 32'(step_of(c, map_w_q));
    res.sy    = 32'(step_of(s, map_h_q));
    return res;
  endfunction

  // result checking
  always @(posedge clk_i) begin
    ray_res_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_rays.size() == 0) begin
        $error("unexpected result %h", got);
        err_cnt++;
      end else begin
        want = pending_rays.pop_front();
        if (got.angle !== want.angle) begin
          $error("ray_angle exp %0d got %0d", want.angle, got.angle); err_cnt++;
        end
        if (got.cosv !== want.cosv) begin
          $error("cosine_value exp %0d got %0d", $signed(want.cosv), $signed(got.cosv));
          err_cnt++;
        end
        if (got.sinv !== want.sinv) begin
          $error("sine_value exp %0d got %0d", $signed(want.sinv), $signed(got.sinv));
          err_cnt++;
        end
        if (got.sx !== want.sx) begin
          $error("step_x exp %h got %h", want.sx, got.sx); err_cnt++;
        end
        if (got.sy !== want.sy) begin
          $error("step_y exp %h got %h", want.sy, got.sy); err_cnt++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("ray_direction_setup_tb: done, errors");
      $finish;
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    out_ch.ready <= stall_on ? ($urandom_range(0, 99) >= 21) : 1'b1;
  end

  task automatic write_map(rds_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = {16'(idx), 16'd0, val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == rds_pkg::CfgMapWidth) map_w_q = val;
    else map_h_q = val;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // one request, expectation pushed on acceptance
  task automatic send_ray(logic [14:0] dir, logic [14:0] off, bit typed, ray_res_t res);
    while (stall_on && $urandom_range(0, 99) < 21) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = {dir, off};
    do @(posedge clk_i); while (!in_ch.ready);
    pending_rays.push_back(typed ? res : predict_ray(dir, off));
    @(negedge clk_i);
  endtask

  task automatic drain_rays();
    in_ch.valid = 1'b0;
    while (pending_rays.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // directed stimulus table
  localparam int NumDir = 16;
  logic [14:0] dir_tab [NumDir] = '{15'd0, 15'd25735, 15'd0, 15'd0, 15'd25735, 15'd32767,
    15'd32767, 15'd0, 15'd6434, 15'd12868, 15'd19302, 15'd3217, 15'd3218, 15'd9651,
    15'd16384, 15'd0};
  logic [14:0] off_tab [NumDir] = '{15'd0, 15'd0, 15'd12868, -15'sd12868, -15'sd12868,
    15'h4000, 15'h3fff, 15'h3fff, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'h4000,
    15'd1};
  bit typed_tab [NumDir] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  ray_res_t res_tab [NumDir] = '{
    '{angle: 15'd0, cosv: 16'd16384, sinv: 16'd0, sx: 32'd65536, sy: 32'd0},
    '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};

  task automatic random_rays(int n);
    logic [14:0] d, o;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        // near a quadrant axis so that sine or cosine is small, and for some picks rounds to zero
        d = 15'($urandom_range(0, 3) * 6434 + $urandom_range(0, 2) - 1);
        o = 15'($urandom_range(0, 2) - 1);
      end else begin
        d = 15'($urandom_range(0, 32767));
        o = 15'($urandom_range(0, 32767));
      end
      send_ray(d, o, 1'b0, '0);
      if (i == n / 2) stall_on = ~stall_on;
    end
    stall_on = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < NumDir; k++) send_ray(dir_tab[k], off_tab[k], typed_tab[k], res_tab[k]);
    drain_rays();

    write_map(rds_pkg::CfgMapWidth, 16'd65535);
    write_map(rds_pkg::CfgMapHeight, 16'd65535);
    for (int k = 0; k < NumDir; k++) send_ray(dir_tab[k], off_tab[k], 1'b0, '0);
    random_rays(100);
    drain_rays();

    write_map(rds_pkg::CfgMapWidth, 16'd32768);
    write_map(rds_pkg::CfgMapHeight, 16'd1);
    random_rays(100);
    drain_rays();

    write_map(rds_pkg::CfgMapWidth, 16'd32767);
    write_map(rds_pkg::CfgMapHeight, 16'd12345);
    random_rays(100);
    drain_rays();

    write_map(rds_pkg::CfgMapWidth, 16'd0);
    write_map(rds_pkg::CfgMapHeight, 16'd0);
    random_rays(120);
    drain_rays();

    if (err_cnt == 0) begin
      $display("ray_direction_setup_tb: done, clean");
    end else begin
      $display("ray_direction_setup_tb: done, errors");
    end
    $finish;
  end

endmodule
